// ----- rtl/fsp_pkg.sv -----
// Shared types, codes and character helpers of the fault/stop command parser.
package fsp_pkg;

    localparam int TOKEN_MAX_CHARS_DEF = 8;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_IDX_W           = 1;
    localparam int TOKEN_LEN_W         = 4;
    localparam int POS_W               = 4;
    localparam int VALUE_MAX           = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_TEXT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LENGTH = 1'd1;

    localparam logic [POS_W-1:0] FAULT_WORD_LEN = 4'd6;
    localparam logic [POS_W-1:0] STOP_WORD_LEN  = 4'd5;

    typedef enum logic [1:0] {
        VERDICT_REJECT = 2'd0,
        VERDICT_FAULT  = 2'd1,
        VERDICT_STOP   = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'd0,
        PH_TOKEN  = 4'd1,
        PH_ID     = 4'd2,
        PH_ROW    = 4'd3,
        PH_COL    = 4'd4,
        PH_SEV    = 4'd5,
        PH_TRAIL  = 4'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_verdict   verdict;
        logic [3:0] fault_id;
        logic [1:0] fault_row;
        logic [1:0] fault_col;
        logic [7:0] fault_severity;
    } t_out_word;

    typedef struct packed {
        t_phase           phase;
        logic [POS_W-1:0] char_pos;
        logic             line_is_stop;
        logic [7:0]       number_value;
        logic             digit_seen;
        logic [7:0]       held_id;
        logic [7:0]       held_row;
        logic [7:0]       held_col;
        logic [7:0]       held_severity;
        logic             line_failed;
        logic             text_ended;
    } t_parse_state;

    typedef struct packed {
        logic                   usable;
        logic [TOKEN_LEN_W-1:0] eff_len;
    } t_tok_info;

    localparam t_parse_state PARSE_IDLE = '{
        phase: PH_PREFIX, char_pos: '0, line_is_stop: 1'b0, number_value: '0,
        digit_seen: 1'b0, held_id: '0, held_row: '0, held_col: '0,
        held_severity: '0, line_failed: 1'b0, text_ended: 1'b0
    };

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h0D || c == 8'h0A || c == 8'h20 || c == 8'h09;
    endfunction

    function automatic logic [7:0] prefix_char(input logic is_stop,
                                               input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (is_stop) begin
            case (pos)
                4'd0:    ch = "S";
                4'd1:    ch = "T";
                4'd2:    ch = "O";
                4'd3:    ch = "P";
                4'd4:    ch = ",";
                default: ch = 8'h00;
            endcase
        end else begin
            case (pos)
                4'd0:    ch = "F";
                4'd1:    ch = "A";
                4'd2:    ch = "U";
                4'd3:    ch = "L";
                4'd4:    ch = "T";
                4'd5:    ch = ",";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    // Ids run row by row over a three by three grid.
    function automatic logic cell_ok(input logic [7:0] id, input logic [7:0] row,
                                     input logic [7:0] col);
        logic ok;
        case (id)
            8'd1:    ok = (row == 8'd1) && (col == 8'd1);
            8'd2:    ok = (row == 8'd1) && (col == 8'd2);
            8'd3:    ok = (row == 8'd1) && (col == 8'd3);
            8'd4:    ok = (row == 8'd2) && (col == 8'd1);
            8'd5:    ok = (row == 8'd2) && (col == 8'd2);
            8'd6:    ok = (row == 8'd2) && (col == 8'd3);
            8'd7:    ok = (row == 8'd3) && (col == 8'd1);
            8'd8:    ok = (row == 8'd3) && (col == 8'd2);
            8'd9:    ok = (row == 8'd3) && (col == 8'd3);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ----- rtl/fsp_parse.sv -----
// Per-byte line parser: holds the parse state and computes its next value.
module fsp_parse #(
    parameter int TOKEN_MAX_CHARS = fsp_pkg::TOKEN_MAX_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  fsp_pkg::t_in_word            i_word,
    input  logic [TOKEN_MAX_CHARS*8-1:0] i_token_text,
    input  fsp_pkg::t_tok_info           i_tok,
    output fsp_pkg::t_parse_state        o_next
);
    import fsp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    logic [7:0]   c;
    logic [7:0]   tok_ch;
    logic         is_stop;
    logic [POS_W-1:0] wlen;
    logic [POS_W-1:0] pos_inc;
    logic [11:0]  num_sum;

    assign c = i_word.text_byte;

    always_comb begin
        tok_ch = 8'h00;
        for (int i = 0; i < TOKEN_MAX_CHARS; i++) begin
            if (r_state.char_pos == POS_W'(i)) begin
                tok_ch = i_token_text[i*8 +: 8];
            end
        end
    end

    assign pos_inc = r_state.char_pos + 4'd1;
    assign num_sum = {1'b0, r_state.number_value, 3'b000}
                   + {3'b000, r_state.number_value, 1'b0}
                   + {4'd0, c - 8'h30};
    assign is_stop = (r_state.char_pos == '0) ? (c == "S") : r_state.line_is_stop;
    assign wlen    = is_stop ? STOP_WORD_LEN : FAULT_WORD_LEN;

    always_comb begin
        n_state = r_state;
        if (!r_state.text_ended) begin
            if (c == 8'h00) begin
                n_state.text_ended = 1'b1;
            end else if (!r_state.line_failed) begin
                case (r_state.phase)
                    PH_PREFIX: begin
                        n_state.line_is_stop = is_stop;
                        if (r_state.char_pos >= wlen ||
                            c != prefix_char(is_stop, r_state.char_pos)) begin
                            n_state.line_failed = 1'b1;
                        end else if (pos_inc == wlen) begin
                            n_state.phase    = PH_TOKEN;
                            n_state.char_pos = '0;
                        end else begin
                            n_state.char_pos = pos_inc;
                        end
                    end
                    PH_TOKEN: begin
                        if (r_state.char_pos < i_tok.eff_len) begin
                            if (c != tok_ch) n_state.line_failed = 1'b1;
                            else             n_state.char_pos    = pos_inc;
                        end else if (r_state.line_is_stop) begin
                            if (is_space(c)) n_state.phase       = PH_TRAIL;
                            else             n_state.line_failed = 1'b1;
                        end else if (c == ",") begin
                            n_state.phase        = PH_ID;
                            n_state.number_value = '0;
                            n_state.digit_seen   = 1'b0;
                        end else begin
                            n_state.line_failed = 1'b1;
                        end
                    end
                    PH_ID, PH_ROW, PH_COL, PH_SEV: begin
                        if (c >= "0" && c <= "9") begin
                            if (num_sum > 12'(VALUE_MAX)) begin
                                n_state.line_failed = 1'b1;
                            end else begin
                                n_state.number_value = num_sum[7:0];
                                n_state.digit_seen   = 1'b1;
                            end
                        end else if (!r_state.digit_seen) begin
                            n_state.line_failed = 1'b1;
                        end else if (r_state.phase == PH_SEV) begin
                            if (is_space(c)) begin
                                n_state.held_severity = r_state.number_value;
                                n_state.phase         = PH_TRAIL;
                            end else begin
                                n_state.line_failed = 1'b1;
                            end
                        end else if (c != ",") begin
                            n_state.line_failed = 1'b1;
                        end else begin
                            n_state.number_value = '0;
                            n_state.digit_seen   = 1'b0;
                            case (r_state.phase)
                                PH_ID: begin
                                    n_state.held_id = r_state.number_value;
                                    n_state.phase   = PH_ROW;
                                end
                                PH_ROW: begin
                                    n_state.held_row = r_state.number_value;
                                    n_state.phase    = PH_COL;
                                end
                                default: begin
                                    n_state.held_col = r_state.number_value;
                                    n_state.phase    = PH_SEV;
                                end
                            endcase
                        end
                    end
                    PH_TRAIL: begin
                        if (!is_space(c)) n_state.line_failed = 1'b1;
                    end
                    default: begin
                        n_state.line_failed = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_next = n_state;

    // The state goes back to the start of a line after the word that ends it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_IDLE;
        end else if (i_adv) begin
            r_state <= i_word.last_byte ? PARSE_IDLE : n_state;
        end
    end

endmodule

// ----- rtl/fsp_judge.sv -----
// Verdict logic: turns the parse state after a line's last byte into a result word.
module fsp_judge (
    input  fsp_pkg::t_parse_state i_state,
    input  fsp_pkg::t_tok_info    i_tok,
    output fsp_pkg::t_out_word    o_word
);
    import fsp_pkg::*;

    logic       sev_open;
    logic [7:0] sev;
    logic       fault_ok;
    logic       stop_ok;

    // A severity still being read at the end of the line counts as complete.
    assign sev_open = (i_state.phase == PH_SEV) && i_state.digit_seen;
    assign sev      = sev_open ? i_state.number_value : i_state.held_severity;

    assign stop_ok = (i_state.phase == PH_TRAIL) ||
                     (i_state.phase == PH_TOKEN && i_state.char_pos == i_tok.eff_len);

    assign fault_ok = (sev_open || i_state.phase == PH_TRAIL) &&
                      cell_ok(i_state.held_id, i_state.held_row, i_state.held_col) &&
                      (sev != 8'd0);

    always_comb begin
        o_word = '{verdict: VERDICT_REJECT, default: '0};
        if (!i_state.line_failed && i_tok.usable) begin
            if (i_state.line_is_stop) begin
                if (stop_ok) o_word.verdict = VERDICT_STOP;
            end else if (fault_ok) begin
                o_word.verdict        = VERDICT_FAULT;
                o_word.fault_id       = i_state.held_id[3:0];
                o_word.fault_row      = i_state.held_row[1:0];
                o_word.fault_col      = i_state.held_col[1:0];
                o_word.fault_severity = sev;
            end
        end
    end

endmodule

// ----- rtl/fsp_out_reg.sv -----
// Result register toward the output channel.
module fsp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fsp_pkg::t_out_word i_word,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output fsp_pkg::t_out_word o_word
);
    import fsp_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_word <= i_word;
        end
    end

endmodule

// ----- rtl/fault_stop_command_parser_top.sv -----
// Top level of the fault/stop command parser: input register, parser, verdict and result register.
//
// The block reads a command line one character per word and takes a new word in every cycle
// while o_in_stall is low. A word passes an input register and then updates the parse state;
// the word that ends a line also loads the verdict into the result register, which drives the
// output. Only a last-byte word waiting on a full, stalled result register holds the input
// side; the result register is freed in the same cycle in which the output takes its word.
// The user must write the token registers over the configuration port only while no line is
// in flight; the block does not enforce this. o_cfg_ready is always high.
module fault_stop_command_parser_top #(
    parameter int TOKEN_MAX_CHARS = fsp_pkg::TOKEN_MAX_CHARS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  fsp_pkg::t_in_word                  i_in_word,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output fsp_pkg::t_out_word                 o_out_word,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fsp_pkg::*;

    logic [TOKEN_MAX_CHARS*8-1:0] r_token_text;
    logic [TOKEN_LEN_W-1:0]       r_token_len;
    logic                         r_in_valid;
    t_in_word                     r_in_word;
    t_tok_info                    tok;
    t_parse_state                 next_state;
    t_out_word                    verdict_word;
    logic                         out_free;
    logic                         adv;
    logic                         in_accept;
    logic                         chars_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_text <= '0;
            r_token_len  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOKEN_TEXT:   r_token_text <= i_cfg_data[TOKEN_MAX_CHARS*8-1:0];
                CFG_TOKEN_LENGTH: r_token_len  <= i_cfg_data[TOKEN_LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // A token character that is zero, a comma or white space makes the token unusable.
    always_comb begin
        chars_ok = 1'b1;
        for (int i = 0; i < TOKEN_MAX_CHARS; i++) begin
            if (TOKEN_LEN_W'(i) < r_token_len) begin
                if (r_token_text[i*8 +: 8] == 8'h00 || r_token_text[i*8 +: 8] == "," ||
                    is_space(r_token_text[i*8 +: 8])) begin
                    chars_ok = 1'b0;
                end
            end
        end
    end

    assign tok = '{
        usable:  chars_ok && (r_token_len != '0) &&
                 (r_token_len <= TOKEN_LEN_W'(TOKEN_MAX_CHARS)),
        eff_len: (r_token_len > TOKEN_LEN_W'(TOKEN_MAX_CHARS)) ?
                 TOKEN_LEN_W'(TOKEN_MAX_CHARS) : r_token_len
    };

    assign adv        = r_in_valid && (!r_in_word.last_byte || out_free);
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept || adv) begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    fsp_parse #(
        .TOKEN_MAX_CHARS (TOKEN_MAX_CHARS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_word       (r_in_word),
        .i_token_text (r_token_text),
        .i_tok        (tok),
        .o_next       (next_state)
    );

    fsp_judge u_judge (
        .i_state (next_state),
        .i_tok   (tok),
        .o_word  (verdict_word)
    );

    fsp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && r_in_word.last_byte),
        .i_word  (verdict_word),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

// ----- rtl/fsp_checker.sv -----
// Port-level checks of the fault/stop command parser and their binding to the top level.
module fsp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input fsp_pkg::t_out_word             o_out_word,
    input logic                           i_out_stall
);
    import fsp_pkg::*;

    // Fault fields stay zero unless a fault line was accepted.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.verdict != VERDICT_FAULT |->
            o_out_word.fault_id == '0 && o_out_word.fault_row == '0 &&
            o_out_word.fault_col == '0 && o_out_word.fault_severity == '0)
        else $error("fault fields set on a word that is not a fault");

    // An accepted fault names a real grid cell and a nonzero severity.
    a_fault_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.verdict == VERDICT_FAULT |->
            o_out_word.fault_row != 2'd0 && o_out_word.fault_col != 2'd0 &&
            o_out_word.fault_id != 4'd0 && o_out_word.fault_severity != 8'd0)
        else $error("accepted fault with an empty field");

    // The input only stalls behind a result word that is waiting on the output.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while the result register is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

endmodule

bind fault_stop_command_parser_top fsp_checker u_fsp_checker (.*);

// ----- sim/tb_fault_stop_command_parser_top.sv -----
// Self-checking testbench of the fault/stop command parser: line stimulus, verdict prediction, result check.
module tb_fault_stop_command_parser_top;
    import fsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER  = 10;
    localparam int GRID_SIDE   = 3;
    localparam int ID_MAX      = 9;

    localparam logic [47:0] FAULT_WORD = "FAULT,";
    localparam logic [39:0] STOP_WORD  = "STOP,";
    localparam logic [7:0]  CH_COMMA   = ",";
    localparam logic [7:0]  CH_ZERO    = "0";
    localparam logic [7:0]  CH_NINE    = "9";
    localparam logic [7:0]  CH_S       = "S";

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_word   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Mirror of the token registers and of the line parse state.
    logic [63:0] tok_text = '0;
    logic [3:0]  tok_len  = '0;
    t_phase      ln_phase;
    logic [3:0]  ln_pos;
    logic        ln_stop;
    logic [7:0]  ln_num;
    logic        ln_digit;
    logic [7:0]  ln_id;
    logic [7:0]  ln_row;
    logic [7:0]  ln_col;
    logic [7:0]  ln_sev;
    logic        ln_failed;
    logic        ln_ended;

    t_in_word    pend_words[$];
    t_out_word   due_verdicts[$];
    logic [7:0]  line_buf[$];
    t_out_word   want_word;
    logic        word_taken   = 1'b0;
    int unsigned queued_bytes = 0;
    int unsigned results_seen = 0;
    int unsigned fails        = 0;
    int unsigned cycles       = 0;
    int unsigned idle_pct     = 38;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;

    fault_stop_command_parser_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h0D || c == 8'h0A || c == 8'h20 || c == 8'h09;
    endfunction

    function automatic logic [3:0] tok_eff();
        return (tok_len > TOKEN_MAX_CHARS_DEF) ? 4'(TOKEN_MAX_CHARS_DEF) : tok_len;
    endfunction

    function automatic logic tok_usable();
        logic       ok;
        logic [7:0] ch;
        ok = (tok_len >= 1) && (tok_len <= TOKEN_MAX_CHARS_DEF);
        for (int k = 0; k < TOKEN_MAX_CHARS_DEF; k++) begin
            ch = tok_text[8*k +: 8];
            if (k < tok_len && (ch == 8'h00 || ch == CH_COMMA || is_blank(ch)))
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic void clear_line();
        ln_phase  = PH_PREFIX;
        ln_pos    = '0;
        ln_stop   = 1'b0;
        ln_num    = '0;
        ln_digit  = 1'b0;
        ln_id     = '0;
        ln_row    = '0;
        ln_col    = '0;
        ln_sev    = '0;
        ln_failed = 1'b0;
        ln_ended  = 1'b0;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [3:0]  wlen;
        logic [7:0]  want;
        int          p;
        int unsigned acc;
        case (ln_phase)
            PH_PREFIX: begin
                if (ln_pos == 0)
                    ln_stop = (c == CH_S);
                wlen = ln_stop ? STOP_WORD_LEN : FAULT_WORD_LEN;
                p = ln_pos;
                if (ln_pos >= wlen) begin
                    ln_failed = 1'b1;
                end else begin
                    want = ln_stop ? STOP_WORD[39 - 8*p -: 8] : FAULT_WORD[47 - 8*p -: 8];
                    if (c != want) begin
                        ln_failed = 1'b1;
                    end else begin
                        ln_pos++;
                        if (ln_pos == wlen) begin
                            ln_phase = PH_TOKEN;
                            ln_pos   = '0;
                        end
                    end
                end
            end
            PH_TOKEN: begin
                if (ln_pos < tok_eff()) begin
                    if (c != tok_text[8*ln_pos[2:0] +: 8])
                        ln_failed = 1'b1;
                    else
                        ln_pos++;
                end else if (ln_stop) begin
                    if (is_blank(c))
                        ln_phase = PH_TRAIL;
                    else
                        ln_failed = 1'b1;
                end else if (c == CH_COMMA) begin
                    ln_phase = PH_ID;
                    ln_num   = '0;
                    ln_digit = 1'b0;
                end else begin
                    ln_failed = 1'b1;
                end
            end
            PH_ID, PH_ROW, PH_COL, PH_SEV: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    acc = 10 * int'(ln_num) + int'(c) - int'(CH_ZERO);
                    if (acc > VALUE_MAX) begin
                        ln_failed = 1'b1;
                    end else begin
                        ln_num   = acc[7:0];
                        ln_digit = 1'b1;
                    end
                end else if (!ln_digit) begin
                    ln_failed = 1'b1;
                end else if (ln_phase == PH_SEV) begin
                    if (is_blank(c)) begin
                        ln_sev   = ln_num;
                        ln_phase = PH_TRAIL;
                    end else begin
                        ln_failed = 1'b1;
                    end
                end else if (c != CH_COMMA) begin
                    ln_failed = 1'b1;
                end else begin
                    case (ln_phase)
                        PH_ID:   ln_id  = ln_num;
                        PH_ROW:  ln_row = ln_num;
                        default: ln_col = ln_num;
                    endcase
                    ln_phase = t_phase'(ln_phase + 4'd1);
                    ln_num   = '0;
                    ln_digit = 1'b0;
                end
            end
            PH_TRAIL: begin
                if (!is_blank(c))
                    ln_failed = 1'b1;
            end
            default: ln_failed = 1'b1;
        endcase
    endfunction

    function automatic t_out_word line_verdict();
        t_out_word r;
        logic      ok;
        r = '0;
        r.verdict = VERDICT_REJECT;
        if (ln_failed || !tok_usable())
            return r;
        if (ln_stop) begin
            if (ln_phase == PH_TRAIL || (ln_phase == PH_TOKEN && ln_pos == tok_eff()))
                r.verdict = VERDICT_STOP;
            return r;
        end
        // A line may end right on the last severity digit.
        if (ln_phase == PH_SEV && ln_digit)
            ln_sev = ln_num;
        else if (ln_phase != PH_TRAIL)
            return r;
        ok = ln_row >= 1 && ln_row <= GRID_SIDE && ln_col >= 1 && ln_col <= GRID_SIDE &&
             ln_id >= 1 && ln_id <= ID_MAX && ln_sev != 0;
        if (ok)
            ok = (ln_row == (ln_id - 1) / GRID_SIDE + 1) && (ln_col == (ln_id - 1) % GRID_SIDE + 1);
        if (ok) begin
            r.verdict        = VERDICT_FAULT;
            r.fault_id       = ln_id[3:0];
            r.fault_row      = ln_row[1:0];
            r.fault_col      = ln_col[1:0];
            r.fault_severity = ln_sev;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    // Prediction runs on every word the block accepts.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            word_taken = 1'b1;
            if (!ln_ended) begin
                if (i_in_word.text_byte == 8'h00)
                    ln_ended = 1'b1;
                else if (!ln_failed)
                    parse_char(i_in_word.text_byte);
            end
            if (i_in_word.last_byte) begin
                due_verdicts.push_back(line_verdict());
                clear_line();
            end
        end
    end

    always @(negedge i_clk) begin
        if (word_taken || !i_in_valid) begin
            word_taken = 1'b0;
            if (pend_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word  <= pend_words.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_verdicts.size() == 0) begin
                $error("result word with no line pending: %p", o_out_word);
                fails++;
            end else begin
                want_word = due_verdicts.pop_front();
                check_field("verdict", want_word.verdict, o_out_word.verdict);
                check_field("fault_id", want_word.fault_id, o_out_word.fault_id);
                check_field("fault_row", want_word.fault_row, o_out_word.fault_row);
                check_field("fault_col", want_word.fault_col, o_out_word.fault_col);
                check_field("fault_severity", want_word.fault_severity,
                            o_out_word.fault_severity);
            end
        end
    end

    // One long hold on the output lets the result register fill and back up the input.
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TOKEN_TEXT)
            tok_text = val;
        else
            tok_len = val[3:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_token(input logic [63:0] text, input logic [3:0] len);
        write_reg(CFG_TOKEN_TEXT, text);
        write_reg(CFG_TOKEN_LENGTH, {60'd0, len});
    endtask

    // Waits until every queued word is taken and every verdict is back.
    task automatic settle();
        while (pend_words.size() != 0 || i_in_valid || due_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] make_token(string s);
        logic [63:0] v;
        v = {$urandom, $urandom};
        for (int k = 0; k < s.len(); k++)
            v[8*k +: 8] = s[k];
        return v;
    endfunction

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endtask

    task automatic add_num(input int unsigned v, input int unsigned pad);
        repeat (pad) line_buf.push_back(CH_ZERO);
        add_text($sformatf("%0d", v));
    endtask

    task automatic add_token();
        for (int k = 0; k < tok_eff(); k++)
            line_buf.push_back(tok_text[8*k +: 8]);
    endtask

    task automatic add_blanks(input int unsigned n);
        logic [7:0] pick[4];
        pick = '{8'h0D, 8'h0A, 8'h20, 8'h09};
        repeat (n) line_buf.push_back(pick[$urandom_range(3)]);
    endtask

    task automatic build_fault(input int unsigned id, input int unsigned row,
                               input int unsigned col, input int unsigned sev,
                               input int unsigned trail, input int unsigned pad);
        add_text("FAULT,");
        add_token();
        add_text(",");
        add_num(id, pad);
        add_text(",");
        add_num(row, pad);
        add_text(",");
        add_num(col, pad);
        add_text(",");
        add_num(sev, pad);
        add_blanks(trail);
    endtask

    task automatic build_stop(input int unsigned trail);
        add_text("STOP,");
        add_token();
        add_blanks(trail);
    endtask

    task automatic send_line();
        t_in_word w;
        foreach (line_buf[k]) begin
            w.text_byte = line_buf[k];
            w.last_byte = (k == line_buf.size() - 1);
            pend_words.push_back(w);
        end
        queued_bytes += line_buf.size();
        line_buf.delete();
    endtask

    function automatic int unsigned odd_value();
        return $urandom_range(1) ? $urandom_range(4) : $urandom_range(300);
    endfunction

    task automatic directed_lines();
        build_fault(1, 1, 1, 1, 0, 0);    send_line();
        build_fault(9, 3, 3, 255, 0, 0);  send_line();
        build_fault(5, 2, 2, 256, 0, 0);  send_line();
        build_fault(0, 1, 1, 5, 0, 0);    send_line();
        build_fault(4, 2, 1, 0, 0, 0);    send_line();
        // The id names a different cell than row and column.
        build_fault(2, 1, 3, 7, 0, 0);    send_line();
        build_fault(7, 4, 1, 7, 0, 0);    send_line();
        build_fault(6, 2, 3, 9, 4, 0);    send_line();
        build_fault(8, 3, 2, 200, 0, 2);  send_line();
        build_stop(0);                    send_line();
        build_stop(3);                    send_line();
        // A zero byte ends the text and everything after it is ignored.
        build_stop(0);
        line_buf.push_back(8'h00);
        add_text("xyz");
        send_line();
        add_text("FAULT,");
        add_token();
        add_text(",3,1,3,12");
        line_buf.push_back(8'h00);
        add_text(",");
        send_line();
        line_buf.push_back(8'h00);        send_line();
        line_buf.push_back(8'hFF);        send_line();
        add_text("S");                    send_line();
        add_text("FAULT,");
        add_token();
        add_text(",3,1,");
        send_line();
        add_text("FAULX,");
        add_token();
        add_text(",1,1,1,1");
        send_line();
        add_text("FAULT,");
        add_token();
        add_text(",,1,1,1");
        send_line();
        add_text("FAULT,");
        add_token();
        add_text(",1,1,1,2550");
        send_line();
        build_fault(1, 1, 1, 1, 1, 0);
        add_text("x");
        send_line();
        add_text("STOP,");
        add_token();
        add_text("x");
        send_line();
        add_text("STOP,");
        add_token();
        add_text(", ");
        send_line();
        // Token cut one character short.
        build_stop(0);
        line_buf.delete(line_buf.size() - 1);
        send_line();
    endtask

    task automatic rand_line();
        int unsigned kind;
        int unsigned id;
        int unsigned row;
        int unsigned col;
        int unsigned sev;
        int unsigned trail;
        int unsigned pad;
        int unsigned p;
        int unsigned n;
        logic [7:0]  alphabet[$];
        kind  = $urandom_range(99);
        trail = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        pad   = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
        if (kind < 80) begin
            if ($urandom_range(99) < 70) begin
                id  = $urandom_range(1, 9);
                row = (id - 1) / GRID_SIDE + 1;
                col = (id - 1) % GRID_SIDE + 1;
                sev = $urandom_range(1, 255);
                if ($urandom_range(4) == 0) begin
                    case ($urandom_range(3))
                        0:       id  = odd_value();
                        1:       row = odd_value();
                        2:       col = odd_value();
                        default: sev = odd_value();
                    endcase
                end
                build_fault(id, row, col, sev, trail, pad);
            end else begin
                build_stop(trail);
            end
            // Broken lines: one byte hit, cut short, split by a zero, or missing a byte.
            if (kind >= 55) begin
                p = $urandom_range(line_buf.size() - 1);
                case ($urandom_range(3))
                    0: line_buf[p] = 8'($urandom_range(255));
                    1: while (line_buf.size() > p + 1) line_buf.delete(line_buf.size() - 1);
                    2: line_buf.insert(p, 8'h00);
                    default: line_buf.delete(p);
                endcase
                if (line_buf.size() == 0)
                    line_buf.push_back(8'h00);
            end
        end else begin
            alphabet = '{"F", "A", "U", "L", "T", "S", "O", "P", ",", "0", "5", "9",
                         8'h20, 8'h09, 8'h0D, 8'h0A, 8'h00};
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(1))
                    line_buf.push_back(8'($urandom_range(255)));
                else
                    line_buf.push_back(alphabet[$urandom_range(alphabet.size() - 1)]);
            end
        end
        send_line();
    endtask

    task automatic rand_lines(input int unsigned budget);
        int unsigned start;
        start = queued_bytes;
        while (queued_bytes - start < budget)
            rand_line();
    endtask

    initial begin
        logic [63:0] tv;
        logic [7:0]  ch;
        clear_line();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Token registers still hold their reset values, so every line is rejected.
        rand_lines(20);
        settle();
        set_token(make_token("Tk9"), 4'd3);
        directed_lines();
        rand_lines(60);
        settle();

        idle_pct = 0;
        set_token(make_token("A1b2C3d4"), 4'd8);
        rand_lines(80);
        settle();
        idle_pct = 38;

        set_token('1, 4'd8);
        rand_lines(30);
        settle();
        set_token(make_token("x"), 4'd1);
        rand_lines(40);
        settle();

        // Settings that leave the token unusable.
        set_token(make_token("Q7"), 4'd15);
        rand_lines(20);
        settle();
        set_token(make_token("ab,c"), 4'd4);
        rand_lines(20);
        settle();
        set_token(make_token("p q"), 4'd3);
        rand_lines(10);
        settle();
        set_token('0, 4'd8);
        rand_lines(20);
        settle();
        set_token(make_token("Zz9Zz9Zz"), 4'd9);
        rand_lines(20);
        settle();

        tv = {$urandom, $urandom};
        for (int k = 0; k < 5; k++) begin
            do ch = 8'($urandom_range(33, 126)); while (ch == CH_COMMA);
            tv[8*k +: 8] = ch;
        end
        set_token(tv, 4'd5);
        rand_lines(40);
        settle();

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
